// ----- rtl/ate_pkg.sv -----
// Shared constants for the animation timing evaluator: field widths,
// input mode codes, configuration register indexes and divider step count.
// No dependencies.
`default_nettype none

package ate_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int REP_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fraction is Q0.16, so the divider runs 32 integer steps and 16 fraction steps
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = TIME_W + FRAC_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_EVAL   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION      = 3'd0,
        CFG_REPEAT_TOTAL  = 3'd1,
        CFG_FILL_FREEZE   = 3'd2,
        CFG_SET_KIND      = 3'd3,
        CFG_START_VALUE   = 3'd4,
        CFG_END_VALUE     = 3'd5,
        CFG_DEFAULT_BEGIN = 3'd6,
        CFG_UNUSED        = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- rtl/ate_in_if.sv -----
// Input channel of the animation timing evaluator: valid/ready plus mode and time.
// Depends on ate_pkg.
`default_nettype none

interface ate_in_if;
    import ate_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output mode, output time_ms, input ready);
    modport sink   (input valid, input mode, input time_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/ate_out_if.sv -----
// Result channel of the animation timing evaluator: valid/ready plus active,
// holding and the Q16.16 value. Depends on ate_pkg.
`default_nettype none

interface ate_out_if;
    import ate_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      active;
    logic                      holding;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output active, output holding, output value, input ready);
    modport sink   (input valid, input active, input holding, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/animation_timing_evaluator.sv -----
// Top level of the animation timing evaluator: begin-time list, sequencer,
// shared restoring divider and interpolation multiply. Depends on ate_pkg,
// ate_in_if and ate_out_if.
//
//  Channel   Dir  Handshake             Payload
//  i_in      in   valid/ready           mode[1:0], time_ms[31:0]
//  o_out     out  valid/ready           active, holding, value[31:0] (Q16.16)
//  i_cfg_*   in   write enable only     i_cfg_index[2:0], i_cfg_data[31:0]
//
// A clear, append or unused item goes from transfer through S_DONE to the result.
// An evaluation scans the begin memory, then does the pick, the repeat product
// and the end check; an animate evaluation still running then takes 48 steps
// of the shared restoring divider that yields remainder and Q0.16 fraction,
// then the interpolation multiply and the rounding add; last come the result
// register load and the output transfer.
// Input ready is high only while the sequencer is idle; a finished result
// waits in the output register while a stalled sink holds it.
// Reset is synchronous, active low; the begin memory is not cleared.
`default_nettype none

module animation_timing_evaluator #(
    parameter int MAX_BEGINS = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    ate_in_if.sink                       i_in,
    ate_out_if.source                    o_out,
    input  wire                          i_cfg_we,
    input  wire [ate_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [ate_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ate_pkg::*;

    localparam int CW = $clog2(MAX_BEGINS + 1);
    localparam int AW = (MAX_BEGINS > 1) ? $clog2(MAX_BEGINS) : 1;
    localparam int SW = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_TOTAL,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    // configuration
    logic [TIME_W-1:0]         r_dur, n_dur;
    logic [REP_W-1:0]          r_rep, n_rep;
    logic                      r_freeze, n_freeze;
    logic                      r_set, n_set;
    logic signed [VALUE_W-1:0] r_start, n_start;
    logic signed [VALUE_W-1:0] r_end, n_end;
    logic [TIME_W-1:0]         r_defbeg, n_defbeg;

    // control
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic              r_first, n_first;
    logic              r_found, n_found;
    logic [SW-1:0]     r_step, n_step;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic [TIME_W-1:0]           r_best, n_best;
    logic [TIME_W-1:0]           r_earliest, n_earliest;
    logic [TIME_W-1:0]           r_doc, n_doc;
    logic [TIME_W-1:0]           r_local, n_local;
    logic [TIME_W+REP_W-1:0]     r_total, n_total;
    logic signed [VALUE_W:0]     r_diff, n_diff;
    logic [TIME_W-1:0]           r_rem, n_rem;
    logic [TIME_W-1:0]           r_num, n_num;
    logic [FRAC_W-1:0]           r_quo, n_quo;
    logic [FRAC_W:0]             r_t16, n_t16;
    logic signed [VALUE_W+FRAC_W+2:0] r_prod, n_prod;
    logic                        r_act, n_act;
    logic                        r_hold, n_hold;
    logic signed [VALUE_W-1:0]   r_val, n_val;
    logic                        r_out_active, n_out_active;
    logic                        r_out_holding, n_out_holding;
    logic signed [VALUE_W-1:0]   r_out_value, n_out_value;

    // begin memory
    logic [TIME_W-1:0] r_mem [MAX_BEGINS];
    logic [TIME_W-1:0] r_rd_data;
    logic              mem_we;

    // shared divider step
    logic [TIME_W:0]   div_sh;
    logic              div_ge;
    logic [TIME_W-1:0] pick;
    logic [TIME_W+REP_W-1:0] local_ext;
    logic signed [VALUE_W+FRAC_W+3:0] rnd;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.active  = r_out_active;
    assign o_out.holding = r_out_holding;
    assign o_out.value   = r_out_value;

    assign mem_we = (r_state == S_IDLE) && i_in.valid && (t_mode'(i_in.mode) == MODE_APPEND)
                    && (r_count < CW'(MAX_BEGINS));

    assign div_sh    = {r_rem, r_num[TIME_W-1]};
    assign div_ge    = (div_sh >= {1'b0, r_dur});
    assign pick      = r_found ? r_best : r_earliest;
    assign local_ext = {{REP_W{1'b0}}, r_local};
    assign rnd       = {r_prod[VALUE_W+FRAC_W+2], r_prod} + (VALUE_W+FRAC_W+4)'(32768);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= i_in.time_ms;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_comb begin
        n_dur = r_dur;  n_rep = r_rep;  n_freeze = r_freeze;  n_set = r_set;
        n_start = r_start;  n_end = r_end;  n_defbeg = r_defbeg;
        n_state = r_state;  n_count = r_count;  n_idx = r_idx;  n_rd_vld = r_rd_vld;
        n_first = r_first;  n_found = r_found;  n_step = r_step;
        n_out_valid = r_out_valid;
        n_best = r_best;  n_earliest = r_earliest;  n_doc = r_doc;  n_local = r_local;
        n_total = r_total;  n_diff = r_diff;  n_rem = r_rem;  n_num = r_num;
        n_quo = r_quo;  n_t16 = r_t16;  n_prod = r_prod;
        n_act = r_act;  n_hold = r_hold;  n_val = r_val;
        n_out_active = r_out_active;  n_out_holding = r_out_holding;
        n_out_value = r_out_value;

        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DURATION:      n_dur    = i_cfg_data;
                CFG_REPEAT_TOTAL:  n_rep    = i_cfg_data[REP_W-1:0];
                CFG_FILL_FREEZE:   n_freeze = i_cfg_data[0];
                CFG_SET_KIND:      n_set    = i_cfg_data[0];
                CFG_START_VALUE:   n_start  = $signed(i_cfg_data);
                CFG_END_VALUE:     n_end    = $signed(i_cfg_data);
                CFG_DEFAULT_BEGIN: n_defbeg = i_cfg_data;
                default: ;
            endcase
        end

        // drop the result once the sink has taken it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_act   = 1'b0;
                    n_hold  = 1'b0;
                    n_val   = '0;
                    n_doc   = i_in.time_ms;
                    n_state = S_DONE;
                    case (t_mode'(i_in.mode))
                        MODE_CLEAR: n_count = '0;
                        MODE_APPEND: begin
                            if (r_count < CW'(MAX_BEGINS)) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_EVAL: begin
                            if (r_count == '0) begin
                                n_found = 1'b1;
                                n_best  = r_defbeg;
                                n_state = S_PICK;
                            end else begin
                                n_found  = 1'b0;
                                n_first  = 1'b1;
                                n_idx    = '0;
                                n_rd_vld = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_vld) begin
                    n_first = 1'b0;
                    if (r_first || r_rd_data < r_earliest) begin
                        n_earliest = r_rd_data;
                    end
                    if (r_rd_data <= r_doc && (!r_found || r_rd_data > r_best)) begin
                        n_best  = r_rd_data;
                        n_found = 1'b1;
                    end
                end
                if (r_idx < r_count) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                n_local = r_doc - pick;
                if (r_doc < pick) begin
                    n_state = S_DONE;
                end else if (r_dur == '0) begin
                    // instant set shows the end value; animate is disabled
                    if (r_set) begin
                        n_act = 1'b1;
                        n_val = r_end;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_TOTAL;
                end
            end
            S_TOTAL: begin
                n_total = (TIME_W+REP_W)'(r_dur) * (TIME_W+REP_W)'(r_rep);
                n_diff  = {r_end[VALUE_W-1], r_end} - {r_start[VALUE_W-1], r_start};
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_set) begin
                    n_state = S_DONE;
                    if (r_rep != '0 && local_ext > r_total) begin
                        n_act  = r_freeze;
                        n_hold = r_freeze;
                        n_val  = r_freeze ? r_end : '0;
                    end else if (r_local > r_dur) begin
                        n_act = 1'b0;
                    end else if (r_local == r_dur) begin
                        n_act  = r_freeze;
                        n_hold = r_freeze;
                        n_val  = r_freeze ? r_end : '0;
                    end else begin
                        n_act = 1'b1;
                        n_val = r_end;
                    end
                end else if (r_rep != '0 && local_ext >= r_total) begin
                    if (r_freeze) begin
                        n_hold  = 1'b1;
                        n_t16   = {1'b1, {FRAC_W{1'b0}}};
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_rem   = '0;
                    n_num   = r_local;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one restoring step: remainder first, then the Q0.16 fraction bits
                n_rem  = div_ge ? TIME_W'(div_sh - {1'b0, r_dur}) : div_sh[TIME_W-1:0];
                n_num  = {r_num[TIME_W-2:0], 1'b0};
                n_quo  = {r_quo[FRAC_W-2:0], div_ge};
                n_step = r_step + 1'b1;
                if (r_step == SW'(DIV_STEPS - 1)) begin
                    n_t16   = {1'b0, r_quo[FRAC_W-2:0], div_ge};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = (VALUE_W+FRAC_W+3)'(r_diff)
                          * (VALUE_W+FRAC_W+3)'($signed({1'b0, r_t16}));
                n_state = S_ADD;
            end
            S_ADD: begin
                // round to nearest, ties up, then drop the 16 fraction bits
                n_act   = 1'b1;
                n_val   = r_start + $signed(rnd[VALUE_W+FRAC_W-1:FRAC_W]);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_active  = r_act;
                    n_out_holding = r_hold;
                    n_out_value   = r_val;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_first     <= 1'b0;
            r_found     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_dur       <= '0;
            r_rep       <= REP_W'(1);
            r_freeze    <= 1'b0;
            r_set       <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
            r_defbeg    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_first     <= n_first;
            r_found     <= n_found;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_dur       <= n_dur;
            r_rep       <= n_rep;
            r_freeze    <= n_freeze;
            r_set       <= n_set;
            r_start     <= n_start;
            r_end       <= n_end;
            r_defbeg    <= n_defbeg;
        end
        r_best        <= n_best;
        r_earliest    <= n_earliest;
        r_doc         <= n_doc;
        r_local       <= n_local;
        r_total       <= n_total;
        r_diff        <= n_diff;
        r_rem         <= n_rem;
        r_num         <= n_num;
        r_quo         <= n_quo;
        r_t16         <= n_t16;
        r_prod        <= n_prod;
        r_act         <= n_act;
        r_hold        <= n_hold;
        r_val         <= n_val;
        r_out_active  <= n_out_active;
        r_out_holding <= n_out_holding;
        r_out_value   <= n_out_value;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BEGINS))
        else $error("begin count exceeds list depth");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dur))
        else $error("divider remainder not below duration");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result overwrote a pending output");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_active) |-> (r_out_value == '0 && !r_out_holding))
        else $error("inactive result carries a value");

endmodule

`default_nettype wire
